@@ hdl/zfsc_pkg.sv @@
// shared types and constants for the zone follow steering controller
// no dependencies; compiled first
package zfsc_pkg;

	localparam int COORD_W = 16;
	localparam int CMD_W   = 16;
	localparam int CODE_W  = 3;
	localparam int IDX_W   = 3;
	localparam int DATA_W  = 16;

	// cordic datapath: coordinates scaled by 2^16 plus headroom for gain
	localparam int CW = 36;
	localparam int ZW = 20;

	localparam logic signed [ZW-1:0]      PI_Q16      = 20'sd205887;
	localparam logic signed [COORD_W-1:0] THETA_PI    = 16'sd12868;
	localparam logic signed [16:0]        HALF_PI_Q12 = 17'sd6434;
	localparam logic signed [COORD_W-1:0] ABSENT_X_MM = -16'sd500;

	localparam logic [15:0] ATAN_TAB [16] = '{
		16'd51472, 16'd30386, 16'd16055, 16'd8150, 16'd4091, 16'd2047, 16'd1024, 16'd512,
		16'd256,   16'd128,   16'd64,    16'd32,   16'd16,   16'd8,    16'd4,    16'd2
	};

	localparam logic [CODE_W-1:0] ZONE_HOLD    = 3'd0;
	localparam logic [CODE_W-1:0] ZONE_INSPECT = 3'd1;
	localparam logic [CODE_W-1:0] ZONE_FOLLOW  = 3'd2;
	localparam logic [CODE_W-1:0] ZONE_STOP    = 3'd3;
	localparam logic [CODE_W-1:0] ZONE_BACK    = 3'd4;

	localparam logic [IDX_W-1:0] REG_TURN_GAIN    = 3'd0;
	localparam logic [IDX_W-1:0] REG_CRUISE_SPEED = 3'd1;
	localparam logic [IDX_W-1:0] REG_FAR_LIMIT    = 3'd2;
	localparam logic [IDX_W-1:0] REG_NEAR_LIMIT   = 3'd3;
	localparam logic [IDX_W-1:0] REG_CAUTION_BAND = 3'd4;
	localparam logic [IDX_W-1:0] REG_HEADING_TOL  = 3'd5;

	typedef struct packed {
		logic                       start;
		logic signed [COORD_W-1:0]  x;
		logic signed [COORD_W-1:0]  y;
	} cord_req_t;

	typedef struct packed {
		logic                       busy;
		logic                       done;
		logic signed [COORD_W-1:0]  theta;
	} cord_res_t;

endpackage

@@ hdl/zfsc_if.sv @@
// handshake channel interfaces: target input, command output, register writes
// depends on zfsc_pkg
interface zfsc_in_if;
	import zfsc_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] head_x;
	logic signed [COORD_W-1:0] head_y;
	logic signed [COORD_W-1:0] tail_x;
	logic signed [COORD_W-1:0] tail_y;
	modport source (output valid, head_x, head_y, tail_x, tail_y, input ready);
	modport sink   (input valid, head_x, head_y, tail_x, tail_y, output ready);
endinterface

interface zfsc_out_if;
	import zfsc_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [CMD_W-1:0]  speed_out;
	logic signed [CMD_W-1:0]  turn_out;
	logic        [CODE_W-1:0] zone_code;
	modport source (output valid, speed_out, turn_out, zone_code, input ready);
	modport sink   (input valid, speed_out, turn_out, zone_code, output ready);
endinterface

interface zfsc_cfg_if;
	import zfsc_pkg::*;
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  index;
	logic [DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/zfsc_cordic.sv @@
// iterative vectoring cordic for atan2, one shift-add step per cycle
// depends on zfsc_pkg
module zfsc_cordic (
	input  logic                clk,
	input  logic                arst_n,
	input  zfsc_pkg::cord_req_t req,
	output zfsc_pkg::cord_res_t res
);
	import zfsc_pkg::*;

	logic signed [CW-1:0]      x_q, y_q, xs, ys, x_n, y_n, xe, ye;
	logic signed [ZW-1:0]      z_q, z_n, tab, z_rnd;
	logic [3:0]                iter_q;
	logic                      busy_q, done_q;
	logic signed [COORD_W-1:0] theta_q;

	assign xs  = x_q >>> iter_q;
	assign ys  = y_q >>> iter_q;
	assign tab = $signed({4'b0, ATAN_TAB[iter_q]});

	always_comb begin
		if (!y_q[CW-1]) begin
			x_n = x_q + ys;
			y_n = y_q - xs;
			z_n = z_q + tab;
		end else begin
			x_n = x_q - ys;
			y_n = y_q + xs;
			z_n = z_q - tab;
		end
	end

	assign z_rnd = z_n + 20'sd8;
	assign xe    = {{4{req.x[COORD_W-1]}}, req.x, 16'b0};
	assign ye    = {{4{req.y[COORD_W-1]}}, req.y, 16'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else if (req.start) begin
			iter_q <= '0;
			if (req.y == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
			end
		end else if (busy_q) begin
			iter_q <= iter_q + 4'd1;
			if (iter_q == 4'd15) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			if (req.y == '0) begin
				theta_q <= req.x[COORD_W-1] ? THETA_PI : '0;
			end else if (req.x[COORD_W-1]) begin
				// left half plane: fold over and start from plus or minus pi
				x_q <= -xe;
				y_q <= -ye;
				z_q <= req.y[COORD_W-1] ? -PI_Q16 : PI_Q16;
			end else begin
				x_q <= xe;
				y_q <= ye;
				z_q <= '0;
			end
		end else if (busy_q) begin
			x_q <= x_n;
			y_q <= y_n;
			z_q <= z_n;
			if (iter_q == 4'd15) begin
				theta_q <= z_rnd[ZW-1:4];
			end
		end
	end

	assign res.busy  = busy_q;
	assign res.done  = done_q;
	assign res.theta = theta_q;

endmodule

@@ hdl/zone_follow_steering_controller.sv @@
// zone follow steering controller top level: sequencer, shared multiplier, registers
// depends on zfsc_pkg, zfsc_if and zfsc_cordic
//
// target channel: one item holds head and tail points in millimetres. an x of
// -500 on either point means no reading, and the stored range and heading
// error are reused. command channel: one item per target item, carrying the
// held speed and turn commands and the zone code. cfg channel: register writes
// by index, always ready, to be written only while the block is idle.
// an item waits on the cordic unless there is no reading or the head y is zero,
// and the next target item can be taken in the cycle after the command is
// loaded. the time per item is set by the sixteen iterations of the cordic
// shift-add unit, with a single 18x18 multiplier shared for the range squares,
// the limit squares and the turn gain product in a six step sequence beside it.
// reset clears commands, range and heading error to zero and loads the
// register defaults. if the receiver stalls, the finished command waits in the
// output register; a further item is accepted meanwhile and its command waits
// in the sequencer until the output register frees.
module zone_follow_steering_controller (
	input logic        clk,
	input logic        arst_n,
	zfsc_in_if.sink    target,
	zfsc_out_if.source command,
	zfsc_cfg_if.sink   cfg
);
	import zfsc_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_CORD = 3'd2;
	localparam logic [2:0] S_ERR  = 3'd3;
	localparam logic [2:0] S_TURN = 3'd4;
	localparam logic [2:0] S_DEC  = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0]  state_q, step_q;

	logic [15:0] turn_gain_q, far_q, near_q, band_q;
	logic [14:0] cruise_q;
	logic [13:0] tol_q;

	logic                     rd_q;
	logic signed [16:0]       sx_q, sy_q;
	logic [33:0]              acc_q, range_q, far4_q, near4_q;
	logic [35:0]              mid4_q;
	logic signed [CMD_W-1:0]  err_q, speed_q, turn_q;
	logic signed [CMD_W-1:0]  speed_out_q, turn_out_q, dec_speed, dec_turn, sat_turn;
	logic [CODE_W-1:0]        code_q, code_out_q, dec_code;
	logic                     out_valid_q;

	logic signed [17:0] mul_a, mul_b;
	logic signed [35:0] prod_q;
	logic [16:0]        nc;
	logic signed [16:0] th_ext, err_n, err_ext, tol_ext;
	logic [35:0]        s36, f36, n36;
	logic               accept, err_big, out_load;

	cord_req_t cord_req;
	cord_res_t cord_res;

	zfsc_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cord_req),
		.res    (cord_res)
	);

	assign accept         = target.valid && target.ready;
	assign target.ready   = (state_q == S_IDLE);
	assign cfg.ready      = 1'b1;
	assign cord_req.start = accept && (target.head_x != ABSENT_X_MM)
		&& (target.tail_x != ABSENT_X_MM);
	assign cord_req.x     = target.head_x;
	assign cord_req.y     = target.head_y;

	// finished command moves to the output register once it is free
	assign out_load = (state_q == S_OUT) && (!out_valid_q || command.ready);

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_gain_q <= 16'd128;
			cruise_q    <= 15'd2048;
			far_q       <= 16'd800;
			near_q      <= 16'd200;
			band_q      <= 16'd50;
			tol_q       <= 14'd2145;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_TURN_GAIN:    turn_gain_q <= cfg.data;
				REG_CRUISE_SPEED: cruise_q    <= cfg.data[14:0];
				REG_FAR_LIMIT:    far_q       <= cfg.data;
				REG_NEAR_LIMIT:   near_q      <= cfg.data;
				REG_CAUTION_BAND: band_q      <= cfg.data;
				REG_HEADING_TOL:  tol_q       <= cfg.data[13:0];
				default: ;
			endcase
		end
	end

	// shared multiplier operand select
	assign nc = {1'b0, near_q} + {1'b0, band_q};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MUL: begin
				case (step_q)
					3'd0: begin
						mul_a = {sx_q[16], sx_q};
						mul_b = {sx_q[16], sx_q};
					end
					3'd1: begin
						mul_a = {sy_q[16], sy_q};
						mul_b = {sy_q[16], sy_q};
					end
					3'd2: begin
						mul_a = $signed({2'b0, far_q});
						mul_b = $signed({2'b0, far_q});
					end
					3'd3: begin
						mul_a = $signed({1'b0, nc});
						mul_b = $signed({1'b0, nc});
					end
					3'd4: begin
						mul_a = $signed({2'b0, near_q});
						mul_b = $signed({2'b0, near_q});
					end
					default: ;
				endcase
			end
			S_TURN: begin
				mul_a = $signed({2'b0, turn_gain_q});
				mul_b = {{2{err_q[CMD_W-1]}}, err_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// heading error from the bearing
	assign th_ext  = {cord_res.theta[COORD_W-1], cord_res.theta};
	assign tol_ext = $signed({3'b0, tol_q});
	assign err_n   = (th_ext <= HALF_PI_Q12) ? th_ext - HALF_PI_Q12 + tol_ext
		: th_ext - HALF_PI_Q12 - tol_ext;

	// turn = gain * err >> 8, saturated to 16 bits
	always_comb begin
		if (prod_q[35:23] == '0 || prod_q[35:23] == '1) begin
			sat_turn = prod_q[23:8];
		end else begin
			sat_turn = prod_q[35] ? 16'sh8000 : 16'sh7fff;
		end
	end

	// zone decision, first match wins
	assign s36     = {2'b0, range_q};
	assign f36     = {2'b0, far4_q};
	assign n36     = {2'b0, near4_q};
	assign err_ext = {err_q[CMD_W-1], err_q};
	assign err_big = (err_ext > tol_ext) || (err_ext < -tol_ext);

	always_comb begin
		dec_speed = speed_q;
		dec_turn  = turn_q;
		dec_code  = ZONE_HOLD;
		if (s36 < f36 && s36 > mid4_q && err_big) begin
			dec_speed = '0;
			dec_turn  = sat_turn;
			dec_code  = ZONE_INSPECT;
		end else if (s36 > f36) begin
			dec_speed = $signed({1'b0, cruise_q});
			dec_turn  = sat_turn;
			dec_code  = ZONE_FOLLOW;
		end else if (s36 < mid4_q && s36 > n36) begin
			dec_speed = '0;
			dec_turn  = '0;
			dec_code  = ZONE_STOP;
		end else if (s36 < n36) begin
			dec_speed = -$signed({1'b0, cruise_q});
			dec_turn  = sat_turn;
			dec_code  = ZONE_BACK;
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			rd_q        <= 1'b0;
			range_q     <= '0;
			err_q       <= '0;
			speed_q     <= '0;
			turn_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (command.valid && command.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						rd_q    <= cord_req.start;
						step_q  <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd2 && rd_q) begin
						range_q <= acc_q + prod_q[33:0];
					end
					if (step_q == 3'd5) begin
						state_q <= S_CORD;
					end
				end
				S_CORD: begin
					if (!rd_q || cord_res.done) begin
						state_q <= S_ERR;
					end
				end
				S_ERR: begin
					if (rd_q) begin
						err_q <= err_n[CMD_W-1:0];
					end
					state_q <= S_TURN;
				end
				S_TURN: begin
					state_q <= S_DEC;
				end
				S_DEC: begin
					speed_q <= dec_speed;
					turn_q  <= dec_turn;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sx_q <= {target.head_x[15], target.head_x} + {target.tail_x[15], target.tail_x};
			sy_q <= {target.head_y[15], target.head_y} + {target.tail_y[15], target.tail_y};
		end
		if (state_q == S_MUL) begin
			case (step_q)
				3'd1: acc_q   <= prod_q[33:0];
				3'd3: far4_q  <= {prod_q[31:0], 2'b00};
				3'd4: mid4_q  <= {prod_q[33:0], 2'b00};
				3'd5: near4_q <= {prod_q[31:0], 2'b00};
				default: ;
			endcase
		end
		if (state_q == S_DEC) begin
			code_q <= dec_code;
		end
		if (out_load) begin
			speed_out_q <= speed_q;
			turn_out_q  <= turn_q;
			code_out_q  <= code_q;
		end
	end

	assign command.valid     = out_valid_q;
	assign command.speed_out = speed_out_q;
	assign command.turn_out  = turn_out_q;
	assign command.zone_code = code_out_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !target.ready)
		else $error("target taken while an item is in progress");

	a_bearing_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ERR) && rd_q |-> cord_res.done && !cord_res.busy)
		else $error("heading error formed before the bearing was finished");

	a_cordic_idle: assert property (@(posedge clk) disable iff (!arst_n)
		target.ready |-> !cord_res.busy)
		else $error("cordic still running while idle");

	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		command.valid && (command.zone_code == ZONE_STOP)
		|-> (command.speed_out == '0) && (command.turn_out == '0))
		else $error("caution stop with nonzero command");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		command.valid |-> command.zone_code <= ZONE_BACK)
		else $error("zone code out of range");

endmodule
